@@ hw/rtl/blp_pkg.sv @@
// Shared types, constants and helpers of the LSB-first bit packer.
package blp_pkg;

  localparam int unsigned WordBits   = 64;
  localparam int unsigned OffBits    = 6;
  localparam int unsigned CountBits  = 7;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CountBits-1:0] MaxCount = CountBits'(64);

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  typedef struct packed {
    req_e                 req;
    logic                 reject;
    logic [CountBits-1:0] count;
    logic [CountBits-1:0] avail;
    logic [WordBits-1:0]  data;
  } op_t;

  function automatic logic [WordBits-1:0] low_mask(logic [CountBits-1:0] n);
    logic [WordBits-1:0] m;
    if (n >= MaxCount) begin
      m = '1;
    end else begin
      m = ~({WordBits{1'b1}} << n);
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/lsb_first_bit_packer.sv @@
// Top level of the LSB-first bit packer: front end, word queue and store back end.
//
//   Channel   Ports                                        Handshake
//   request   req_type_i, bit_count_i, write_data_i        start high, busy low
//   result    read_data_o, bits_done_o, status_o           done_o, one cycle
//
// A rejected or zero-length word is finished in S_IDLE alone; a read, or a write inside
// one 64-bit store word, passes S_IDLE, S_LO and S_HI; a write that crosses a word boundary
// adds S_WR_HI, set by the single write port of the store RAM.
// The result strobe is registered from the back end's last state for the word.
// The store is not swept after reset: bits at or above the write position read as
// zero, so the block takes words right after reset. The receiver cannot stall.
module lsb_first_bit_packer import blp_pkg::*; #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type_i,
  input  logic [CountBits-1:0] bit_count_i,
  input  logic [WordBits-1:0]  write_data_i,
  output logic                 done_o,
  output logic [WordBits-1:0]  read_data_o,
  output logic [CountBits-1:0] bits_done_o,
  output logic                 status_o
);

  localparam int unsigned PosBits = $clog2(STORE_BYTES * 8 + 1);
  localparam int unsigned QWidth  = $bits(op_t) + PosBits;

  logic               accept, q_full, q_valid, q_pop;
  op_t                f_op, b_op;
  logic [PosBits-1:0] f_pos, b_pos;
  logic [QWidth-1:0]  q_out;

  assign accept = start && !q_full;
  assign busy   = q_full;

  blp_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .bit_count_i (bit_count_i),
    .write_data_i(write_data_i),
    .op_o        (f_op),
    .pos_o       (f_pos)
  );

  blp_fifo #(
    .Width(QWidth),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i ({f_op, f_pos}),
    .pop_i  (q_pop),
    .data_o (q_out),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  assign b_op  = op_t'(q_out[QWidth-1:PosBits]);
  assign b_pos = q_out[PosBits-1:0];

  blp_back #(
    .STORE_BYTES(STORE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .op_i       (b_op),
    .pos_i      (b_pos),
    .pop_o      (q_pop),
    .done_o     (done_o),
    .read_data_o(read_data_o),
    .bits_done_o(bits_done_o),
    .status_o   (status_o)
  );

endmodule

@@ hw/rtl/blp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module blp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/blp_fifo.sv @@
// Short queue between the front end and the back end.
module blp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntBits = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(Depth);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [CntBits-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == FullCnt);

endmodule

@@ hw/rtl/blp_front.sv @@
// Front end: keeps both bit positions, checks capacity and classifies each word.
module blp_front import blp_pkg::*; #(
  parameter int unsigned STORE_BYTES = 1024,
  localparam int unsigned PosBits = $clog2(STORE_BYTES * 8 + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 req_type_i,
  input  logic [CountBits-1:0] bit_count_i,
  input  logic [WordBits-1:0]  write_data_i,
  output op_t                  op_o,
  output logic [PosBits-1:0]   pos_o
);

  localparam logic [PosBits:0] CapBits = (PosBits + 1)'(STORE_BYTES * 8);

  logic [PosBits-1:0] wpos_q, wpos_d, rpos_q, rpos_d;
  logic [PosBits-1:0] pos_sel, gap;
  logic [PosBits:0]   end_pos;
  logic               is_read, reject;
  logic [CountBits-1:0] avail;

  always_comb begin
    is_read = (req_e'(req_type_i) == REQ_READ);
    pos_sel = is_read ? rpos_q : wpos_q;
    end_pos = {1'b0, pos_sel} + (PosBits + 1)'(bit_count_i);
    reject  = (bit_count_i > MaxCount) || (end_pos > CapBits);
    gap     = wpos_q - rpos_q;
    if (wpos_q <= rpos_q) begin
      avail = '0;
    end else if (gap >= PosBits'(bit_count_i)) begin
      avail = bit_count_i;
    end else begin
      avail = gap[CountBits-1:0];
    end

    wpos_d = wpos_q;
    rpos_d = rpos_q;
    if (accept_i && !reject) begin
      if (is_read) begin
        rpos_d = end_pos[PosBits-1:0];
      end else begin
        wpos_d = end_pos[PosBits-1:0];
      end
    end

    op_o.req    = req_e'(req_type_i);
    op_o.reject = reject;
    op_o.count  = bit_count_i;
    op_o.avail  = avail;
    op_o.data   = write_data_i;
    pos_o       = pos_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      rpos_q <= '0;
    end else begin
      wpos_q <= wpos_d;
      rpos_q <= rpos_d;
    end
  end

endmodule

@@ hw/rtl/blp_back.sv @@
// Back end: read-modify-write of the word store and result generation.
module blp_back import blp_pkg::*; #(
  parameter int unsigned STORE_BYTES = 1024,
  localparam int unsigned PosBits  = $clog2(STORE_BYTES * 8 + 1),
  localparam int unsigned Words    = (STORE_BYTES + 7) / 8,
  localparam int unsigned AddrBits = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  op_t                  op_i,
  input  logic [PosBits-1:0]   pos_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic [WordBits-1:0]  read_data_o,
  output logic [CountBits-1:0] bits_done_o,
  output logic                 status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_WR_HI
  } state_e;

  state_e               state_q;
  op_t                  op_q;
  logic [AddrBits-1:0]  word_q;
  logic [OffBits-1:0]   off_q;
  logic                 span_q;
  logic [WordBits-1:0]  lo_q, hi_q;
  logic                 done_q, status_q;
  logic [WordBits-1:0]  rdata_out_q;
  logic [CountBits-1:0] bits_done_q;

  logic [PosBits-OffBits-1:0] word_full;
  logic [AddrBits-1:0]        word_in;
  logic [OffBits-1:0]         off_in;
  logic                       span_in;
  logic                       ram_we, ram_re;
  logic [AddrBits-1:0]        ram_waddr, ram_raddr;
  logic [WordBits-1:0]        ram_wdata, ram_rdata;
  logic [2*WordBits-1:0]      both, shifted, fmask, fdata, merged;
  logic [WordBits-1:0]        hi_word, rd_bits, cmask;

  blp_ram #(
    .Width(WordBits),
    .Depth(Words)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    word_full = pos_i[PosBits-1:OffBits];
    word_in   = AddrBits'(word_full);
    off_in    = pos_i[OffBits-1:0];
    span_in   = (CountBits'(off_in) + op_i.count) > MaxCount;

    hi_word = span_q ? ram_rdata : '0;
    both    = {hi_word, lo_q};
    shifted = both >> off_q;
    rd_bits = shifted[WordBits-1:0] & low_mask(op_q.avail);
    cmask   = low_mask(op_q.count);
    fmask   = {{WordBits{1'b0}}, cmask} << off_q;
    fdata   = {{WordBits{1'b0}}, op_q.data & cmask} << off_q;
    merged  = (both & ~fmask) | fdata;

    pop_o     = (state_q == S_IDLE) && valid_i;
    ram_re    = 1'b0;
    ram_raddr = word_in;
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = merged[WordBits-1:0];
    case (state_q)
      S_IDLE: begin
        ram_re = valid_i && !op_i.reject && (op_i.count != '0);
      end
      S_LO: begin
        ram_re    = span_q;
        ram_raddr = word_q + 1'b1;
      end
      S_HI: begin
        ram_we = (op_q.req == REQ_WRITE);
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = word_q + 1'b1;
        ram_wdata = hi_q;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      word_q      <= '0;
      off_q       <= '0;
      span_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      done_q      <= 1'b0;
      status_q    <= 1'b0;
      rdata_out_q <= '0;
      bits_done_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            op_q   <= op_i;
            word_q <= word_in;
            off_q  <= off_in;
            span_q <= span_in;
            if (op_i.reject || (op_i.count == '0)) begin
              done_q      <= 1'b1;
              status_q    <= op_i.reject;
              rdata_out_q <= '0;
              bits_done_q <= op_i.reject ? '0 : op_i.count;
            end else begin
              state_q <= S_LO;
            end
          end
        end
        S_LO: begin
          lo_q    <= ram_rdata;
          state_q <= S_HI;
        end
        S_HI: begin
          status_q    <= 1'b0;
          bits_done_q <= op_q.count;
          if (op_q.req == REQ_READ) begin
            done_q      <= 1'b1;
            rdata_out_q <= rd_bits;
            state_q     <= S_IDLE;
          end else begin
            hi_q        <= merged[2*WordBits-1:WordBits];
            rdata_out_q <= '0;
            if (span_q) begin
              state_q <= S_WR_HI;
            end else begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_WR_HI: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_out_q;
  assign bits_done_o = bits_done_q;
  assign status_o    = status_q;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the LSB-first bit packer, with its own bit store model.
module tb;
  import blp_pkg::*;

  localparam int unsigned StoreBytes  = 1024;
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned CapBits     = StoreBytes * ByteBits;
  localparam int unsigned RandomWords = 1400;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned SettleCycles = 12;
  localparam logic        StatusOk     = 1'b0;
  localparam logic        StatusReject = 1'b1;

  typedef struct packed {
    logic [WordBits-1:0]  read_data;
    logic [CountBits-1:0] bits_done;
    logic                 status;
  } access_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 req_type_i = 1'b0;
  logic [CountBits-1:0] bit_count_i = '0;
  logic [WordBits-1:0]  write_data_i = '0;
  logic                 done_o;
  logic [WordBits-1:0]  read_data_o;
  logic [CountBits-1:0] bits_done_o;
  logic                 status_o;

  logic [ByteBits-1:0] store_bytes [StoreBytes];
  int unsigned         wr_pos;
  int unsigned         rd_pos;
  access_result_t      awaited_results[$];
  int unsigned         error_count;
  int unsigned         cycle_count;
  logic                idling_on;

  lsb_first_bit_packer #(
    .STORE_BYTES (StoreBytes)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .bit_count_i  (bit_count_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .bits_done_o  (bits_done_o),
    .status_o     (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Applies one access to the local store and returns the result it must produce.
  function automatic access_result_t pack_access(req_e r, logic [CountBits-1:0] n,
                                                 logic [WordBits-1:0] d);
    access_result_t res;
    int unsigned    pos;
    int unsigned    i;
    res = '0;
    pos = (r == REQ_READ) ? rd_pos : wr_pos;
    if (n > MaxCount || pos + n > CapBits) begin
      res.status = StatusReject;
      return res;
    end
    for (i = 0; i < n; i++) begin
      if (r == REQ_READ) begin
        res.read_data[i] = store_bytes[(pos + i) / ByteBits][(pos + i) % ByteBits];
      end else begin
        store_bytes[(pos + i) / ByteBits][(pos + i) % ByteBits] = d[i];
      end
    end
    if (r == REQ_READ) begin
      rd_pos += n;
    end else begin
      wr_pos += n;
    end
    res.bits_done = n;
    res.status    = StatusOk;
    return res;
  endfunction

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endtask

  always @(negedge clk_i) begin
    access_result_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        note_error($sformatf("unexpected result: read_data=%h bits_done=%0d status=%0b",
                             read_data_o, bits_done_o, status_o));
      end else begin
        want = awaited_results.pop_front();
        if (read_data_o !== want.read_data || bits_done_o !== want.bits_done ||
            status_o !== want.status) begin
          note_error($sformatf({"result mismatch: expected read_data=%h bits_done=%0d ",
                                "status=%0b, got read_data=%h bits_done=%0d status=%0b"},
                               want.read_data, want.bits_done, want.status,
                               read_data_o, bits_done_o, status_o));
        end
      end
    end
  end

  task automatic pause_sender();
    if (idling_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Presents one word, waits for the clock edge where it was taken and may then pause the sender.
  task automatic send_word(req_e r, logic [CountBits-1:0] n, logic [WordBits-1:0] d);
    logic took;
    took = 1'b0;
    start        <= 1'b1;
    req_type_i   <= r;
    bit_count_i  <= n;
    write_data_i <= d;
    while (!took) begin
      @(negedge clk_i);
      took = !busy;
      @(posedge clk_i);
    end
    awaited_results.push_back(pack_access(r, n, d));
    pause_sender();
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_extremes();
    idling_on = 1'b1;
    send_word(REQ_READ, MaxCount, '1);
    send_word(REQ_WRITE, '0, '1);
    send_word(REQ_WRITE, CountBits'(1), '1);
    send_word(REQ_WRITE, MaxCount, '1);
    send_word(REQ_WRITE, CountBits'(63), {32{2'b10}});
    send_word(REQ_WRITE, CountBits'(7), '0);
    send_word(REQ_WRITE, MaxCount, {$urandom, $urandom});
    send_word(REQ_WRITE, CountBits'(8), 64'h0123_4567_89ab_cdef);
    send_word(REQ_WRITE, CountBits'(65), '1);
    send_word(REQ_WRITE, '1, '1);
    send_word(REQ_WRITE, MaxCount, '0);
    send_word(REQ_READ, '0, '1);
    send_word(REQ_READ, CountBits'(1), '0);
    send_word(REQ_READ, MaxCount, '0);
    send_word(REQ_READ, CountBits'(63), '0);
    send_word(REQ_READ, '1, '0);
    send_word(REQ_READ, CountBits'(65), '0);
    send_word(REQ_READ, CountBits'(7), '0);
    send_word(REQ_READ, CountBits'(8), '0);
    send_word(REQ_READ, MaxCount, '0);
    send_word(REQ_READ, MaxCount, '0);
  endtask

  task automatic test_random_mix();
    int unsigned          k;
    int unsigned          roll;
    logic [CountBits-1:0] n;
    req_e                 r;
    for (k = 0; k < RandomWords; k++) begin
      if (k % 100 == 0) begin
        idling_on = ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        n = CountBits'($urandom_range(0, 15));
      end else if (roll < 85) begin
        n = CountBits'($urandom_range(16, 64));
      end else if (roll < 90) begin
        n = CountBits'($urandom_range(65, 127));
      end else begin
        n = CountBits'($urandom_range(0, 1) ? $urandom_range(63, 64) : $urandom_range(0, 1));
      end
      r = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
      send_word(r, n, {$urandom, $urandom});
    end
  endtask

  // Fills the store to its last bit and writes past it, then drains the read side to the same point and reads past it.
  task automatic test_capacity_edge();
    logic [CountBits-1:0] n;
    idling_on = 1'b0;
    while (wr_pos < CapBits) begin
      n = (CapBits - wr_pos <= MaxCount) ? CountBits'(CapBits - wr_pos)
                                         : CountBits'($urandom_range(33, 64));
      send_word(REQ_WRITE, n, {$urandom, $urandom});
    end
    send_word(REQ_WRITE, CountBits'(1), '1);
    send_word(REQ_WRITE, '0, '1);
    send_word(REQ_WRITE, MaxCount, '1);
    while (rd_pos < CapBits) begin
      n = (CapBits - rd_pos <= MaxCount) ? CountBits'(CapBits - rd_pos)
                                         : CountBits'($urandom_range(33, 64));
      send_word(REQ_READ, n, '0);
    end
    send_word(REQ_READ, CountBits'(1), '0);
    send_word(REQ_READ, '0, '0);
    send_word(REQ_READ, MaxCount, '0);
  endtask

  initial begin
    foreach (store_bytes[j]) store_bytes[j] = '0;
    wr_pos      = 0;
    rd_pos      = 0;
    error_count = 0;
    cycle_count = 0;
    idling_on   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    wait_for_results();
    test_random_mix();
    wait_for_results();
    test_capacity_edge();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
